/* hdl/fpa_pkg.sv */
// shared types, constants and saturation helpers for the q24.8 fixed-point alu
package fpa_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int W          = 32;
  localparam int STEP       = 4;
  localparam int QW         = W + FRAC_BITS;
  localparam int DIV_STAGES = (QW + STEP - 1) / STEP;
  localparam int NW         = DIV_STAGES * STEP;
  localparam int RW         = W + 1;
  localparam int PW         = 2 * W;
  localparam int MW         = PW - FRAC_BITS + 1;
  localparam int SW         = W + FRAC_BITS + 1;
  localparam int LAT        = DIV_STAGES + 2;

  localparam logic [MW-1:0] MAXM = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [MW-1:0] MINM = MAXM + MW'(1);
  localparam logic signed [SW-1:0] MAXS = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINS = ~MAXS;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP, OP_MIN, OP_MAX,
    OP_INC, OP_DEC, OP_TOINT, OP_FROMINT
  } op_t;

  typedef enum logic [1:0] {ST_OK, ST_SAT, ST_DIV0} status_t;
  typedef enum logic [1:0] {CMP_LT, CMP_EQ, CMP_GT} cmp_t;

  typedef struct packed {
    logic [3:0]          req_type;
    logic signed [W-1:0] operand_a;
    logic signed [W-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [W-1:0] result_value;
    logic [1:0]          compare_result;
    logic [1:0]          status;
  } res_t;

  typedef struct packed {
    logic [W-1:0] value;
    logic         sat;
  } sat_t;

  // clamp a magnitude with sign to the signed 32-bit range
  function automatic sat_t sat_mag(input logic [MW-1:0] m, input logic neg);
    sat_t         s;
    logic [W-1:0] t;
    t = m[W-1:0];
    s.sat = 1'b0;
    if (!neg && m > MAXM) begin
      s.value = {1'b0, {(W-1){1'b1}}};
      s.sat   = 1'b1;
    end else if (neg && m > MINM) begin
      s.value = {1'b1, {(W-1){1'b0}}};
      s.sat   = 1'b1;
    end else begin
      s.value = neg ? -t : t;
    end
    return s;
  endfunction

  // clamp a wide signed value to the signed 32-bit range
  function automatic sat_t sat_s(input logic signed [SW-1:0] v);
    sat_t s;
    s.sat = 1'b0;
    if (v > MAXS) begin
      s.value = {1'b0, {(W-1){1'b1}}};
      s.sat   = 1'b1;
    end else if (v < MINS) begin
      s.value = {1'b1, {(W-1){1'b0}}};
      s.sat   = 1'b1;
    end else begin
      s.value = v[W-1:0];
    end
    return s;
  endfunction

endpackage

/* hdl/fpa_mul.sv */
// two-stage unsigned multiplier with round half up of the fraction
module fpa_mul (
  input  logic                 clk,
  input  logic [fpa_pkg::W-1:0]  ma,
  input  logic [fpa_pkg::W-1:0]  mb,
  output logic [fpa_pkg::MW-1:0] m
);
  import fpa_pkg::*;

  logic [PW-1:0] p_r;
  logic [MW-1:0] m_r, m_nxt;

  // drop the fraction and add the half bit
  assign m_nxt = MW'(p_r[PW-1:FRAC_BITS]) + MW'(p_r[FRAC_BITS-1]);

  always_ff @(posedge clk) begin
    p_r <= PW'(ma) * PW'(mb);
    m_r <= m_nxt;
  end

  assign m = m_r;
endmodule

/* hdl/fpa_div.sv */
// pipelined restoring divider, STEP quotient bits per stage
module fpa_div (
  input  logic                 clk,
  input  logic [fpa_pkg::NW-1:0] n,
  input  logic [fpa_pkg::W-1:0]  d,
  output logic [fpa_pkg::NW-1:0] q,
  output logic [fpa_pkg::W-1:0]  r,
  output logic [fpa_pkg::W-1:0]  d_out
);
  import fpa_pkg::*;

  logic [NW-1:0] num_r [DIV_STAGES];
  logic [W-1:0]  rem_r [DIV_STAGES];
  logic [W-1:0]  den_r [DIV_STAGES];
  logic [NW-1:0] num_nxt [DIV_STAGES];
  logic [W-1:0]  rem_nxt [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [NW-1:0] num_in;
    logic [W-1:0]  rem_in;
    logic [W-1:0]  den_in;

    if (s == 0) begin : g_first
      assign num_in = n;
      assign rem_in = '0;
      assign den_in = d;
    end else begin : g_next
      assign num_in = num_r[s-1];
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
    end

    // shift in one numerator bit, subtract when the divisor fits
    always_comb begin
      logic [RW-1:0] rm;
      logic [NW-1:0] nm;
      rm = {1'b0, rem_in};
      nm = num_in;
      for (int i = 0; i < STEP; i++) begin
        rm = {rm[W-1:0], nm[NW-1]};
        nm = {nm[NW-2:0], 1'b0};
        if (rm >= {1'b0, den_in}) begin
          rm    = rm - {1'b0, den_in};
          nm[0] = 1'b1;
        end
      end
      rem_nxt[s] = rm[W-1:0];
      num_nxt[s] = nm;
    end

    always_ff @(posedge clk) begin
      num_r[s] <= num_nxt[s];
      rem_r[s] <= rem_nxt[s];
      den_r[s] <= den_in;
    end
  end

  assign q     = num_r[DIV_STAGES-1];
  assign r     = rem_r[DIV_STAGES-1];
  assign d_out = den_r[DIV_STAGES-1];
endmodule

/* hdl/q24_8_fixed_point_alu.sv */
// path: an accepted transaction passes the input register, the divider pipeline stages and the result register
// throughput: one transaction per cycle, busy is never raised
// the latency is set by the divider pipeline, four quotient bits per stage
// the receiver cannot stall, so every result shows for exactly one cycle
// reset (rst_n low, synchronous) clears the valid bits; no transaction is lost afterwards
module q24_8_fixed_point_alu (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  fpa_pkg::req_t in_req,
  output logic          out_valid,
  output fpa_pkg::res_t out_res
);
  import fpa_pkg::*;

  logic          v0_r;
  req_t          req0_r;
  logic [W-1:0]  mag_a, mag_b;
  logic [MW-1:0] mul_m;
  logic [NW-1:0] div_q;
  logic [W-1:0]  div_r, div_d;
  logic          vld_r [DIV_STAGES];
  req_t          ctl_r [DIV_STAGES];
  logic [MW-1:0] mm_r  [DIV_STAGES-2];
  logic          out_valid_r;
  res_t          out_res_r, res_nxt;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
    req0_r <= in_req;
  end

  // operand magnitudes
  assign mag_a = req0_r.operand_a[W-1] ? -req0_r.operand_a : req0_r.operand_a;
  assign mag_b = req0_r.operand_b[W-1] ? -req0_r.operand_b : req0_r.operand_b;

  fpa_mul u_mul (
    .clk (clk),
    .ma  (mag_a),
    .mb  (mag_b),
    .m   (mul_m)
  );

  fpa_div u_div (
    .clk   (clk),
    .n     (NW'({mag_a, {FRAC_BITS{1'b0}}})),
    .d     (mag_b),
    .q     (div_q),
    .r     (div_r),
    .d_out (div_d)
  );

  // transaction delay line alongside the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= v0_r;
      for (int k = 1; k < DIV_STAGES; k++) vld_r[k] <= vld_r[k-1];
    end
    ctl_r[0] <= req0_r;
    for (int k = 1; k < DIV_STAGES; k++) ctl_r[k] <= ctl_r[k-1];
    mm_r[0] <= mul_m;
    for (int k = 1; k < DIV_STAGES-2; k++) mm_r[k] <= mm_r[k-1];
  end

  // final select and saturation
  always_comb begin
    req_t                c;
    logic                neg;
    logic                up;
    logic [W-1:0]        ma;
    logic [W-1:0]        ti;
    logic signed [SW-1:0] sa, sb;
    sat_t                s;
    c   = ctl_r[DIV_STAGES-1];
    neg = c.operand_a[W-1] != c.operand_b[W-1];
    up  = {div_r, 1'b0} >= {1'b0, div_d};
    ma  = c.operand_a[W-1] ? -c.operand_a : c.operand_a;
    ti  = ma >> FRAC_BITS;
    sa  = SW'(c.operand_a);
    sb  = SW'(c.operand_b);
    s   = '0;
    res_nxt = '0;
    case (c.req_type)
      OP_ADD:     s = sat_s(sa + sb);
      OP_SUB:     s = sat_s(sa - sb);
      OP_MUL:     s = sat_mag(mm_r[DIV_STAGES-3], neg);
      OP_DIV: begin
        if (div_d == '0) begin
          res_nxt.status = ST_DIV0;
        end else begin
          s = sat_mag(MW'(div_q) + MW'(up), neg);
        end
      end
      OP_CMP: begin
        if (c.operand_a < c.operand_b) res_nxt.compare_result = CMP_LT;
        else if (c.operand_a == c.operand_b) res_nxt.compare_result = CMP_EQ;
        else res_nxt.compare_result = CMP_GT;
      end
      OP_MIN: s.value = (c.operand_a < c.operand_b) ? c.operand_a : c.operand_b;
      OP_MAX: s.value = (c.operand_a > c.operand_b) ? c.operand_a : c.operand_b;
      OP_INC:     s = sat_s(sa + SW'(1));
      OP_DEC:     s = sat_s(sa - SW'(1));
      OP_TOINT:   s.value = c.operand_a[W-1] ? -ti : ti;
      OP_FROMINT: s = sat_s(sa <<< FRAC_BITS);
      default:    s = '0;
    endcase
    res_nxt.result_value = s.value;
    if (s.sat) res_nxt.status = ST_SAT;
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[DIV_STAGES-1];
    end
    out_res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result strobe without a transaction accepted LAT cycles earlier");

  a_div0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status == ST_DIV0) |->
      (out_res.result_value == '0 && out_res.compare_result == CMP_LT))
    else $error("divide by zero result not cleared");

  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.compare_result != CMP_LT) |->
      (out_res.status == ST_OK && out_res.result_value == '0))
    else $error("compare result mixed with value or status");
`endif
endmodule

/* dv/tb.sv */
// self-checking testbench for the q24.8 fixed-point alu
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t in_req = '0;
  logic out_valid;
  res_t out_res;

  req_t pending_reqs[$];
  res_t expected_res[$];
  int   mismatches = 0;
  bit   stim_done = 1'b0;
  bit   hold_sender = 1'b0;
  int   gap_left = 0;

  q24_8_fixed_point_alu dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // saturate a wide value to 32 signed bits
  function automatic logic [31:0] clamp_q(input logic signed [95:0] v,
                                          inout logic [1:0] st);
    if (v > 96'sd2147483647) begin
      st = ST_SAT;
      return 32'h7fffffff;
    end else if (v < -96'sd2147483648) begin
      st = ST_SAT;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // exact fixed-point result for one request
  function automatic res_t alu_predict(input req_t r);
    res_t o;
    logic signed [95:0] a, b, v;
    logic [95:0] ma, mb, num, den, q, rem;
    logic neg;
    a = r.operand_a;
    b = r.operand_b;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    o = '0;
    o.status = ST_OK;
    case (r.req_type)
      OP_ADD: o.result_value = clamp_q(a + b, o.status);
      OP_SUB: o.result_value = clamp_q(a - b, o.status);
      OP_MUL, OP_DIV: begin
        if (r.req_type == OP_DIV && b == 0) begin
          o.status = ST_DIV0;
        end else begin
          num = (r.req_type == OP_MUL) ? ma * mb : ma << FRAC_BITS;
          den = (r.req_type == OP_MUL) ? (96'd1 << FRAC_BITS) : mb;
          q = num / den;
          rem = num % den;
          if (rem >= den - rem) q = q + 1;
          v = neg ? -$signed(q) : $signed(q);
          o.result_value = clamp_q(v, o.status);
        end
      end
      OP_CMP: o.compare_result = (a < b) ? CMP_LT : (a == b ? CMP_EQ : CMP_GT);
      OP_MIN: o.result_value = (a < b) ? a[31:0] : b[31:0];
      OP_MAX: o.result_value = (a > b) ? a[31:0] : b[31:0];
      OP_INC: o.result_value = clamp_q(a + 1, o.status);
      OP_DEC: o.result_value = clamp_q(a - 1, o.status);
      OP_TOINT: begin
        q = ma >> FRAC_BITS;
        v = (a < 0) ? -$signed(q) : $signed(q);
        o.result_value = v[31:0];
      end
      OP_FROMINT: o.result_value = clamp_q(a * 96'sd256, o.status);
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 1023) - 512;
      3: return {{20{$urandom_range(0, 1) == 1}}, 12'($urandom)};
      4: return 32'($urandom_range(0, 1)) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // driver: one transaction per accept, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_res.push_back(alu_predict(in_req));
      if (gap_left == 0 && !hold_sender && pending_reqs.size() != 0) begin
        in_req <= pending_reqs.pop_front();
        gap_left <= ($urandom_range(0, 9) < 6) ? 0 :
                    ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                                : $urandom_range(1, 3));
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (!hold_sender && pending_reqs.size() != 0) begin
        in_req <= pending_reqs.pop_front();
        start <= 1'b1;
        gap_left <= ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 5);
      end
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid) begin
      if (expected_res.size() == 0) begin
        $error("unexpected result value=%h", out_res.result_value);
        mismatches++;
      end else begin
        e = expected_res.pop_front();
        if (out_res.result_value !== e.result_value) begin
          $error("result_value exp %h got %h", e.result_value, out_res.result_value);
          mismatches++;
        end
        if (out_res.compare_result !== e.compare_result) begin
          $error("compare_result exp %0d got %0d", e.compare_result,
                 out_res.compare_result);
          mismatches++;
        end
        if (out_res.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_res.status);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    req_t r;
    logic [31:0] ext[6];
    ext = '{32'h7fffffff, 32'h80000000, 32'd0, 32'd1, 32'hffffffff, 32'h100};
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed: every opcode with extremes, divide by zero, unused codes
    for (int op = 0; op <= 15; op++) begin
      r.req_type = 4'(op);
      r.operand_a = ext[op % 6];
      r.operand_b = (op == OP_DIV) ? 32'd0 : ext[(op + 1) % 6];
      pending_reqs.push_back(r);
    end
    r = '{OP_MIN, 32'd77, 32'd77};
    pending_reqs.push_back(r);
    r = '{OP_MAX, 32'h80000000, 32'h80000000};
    pending_reqs.push_back(r);
    r = '{OP_MUL, 32'h80000000, 32'h80000000};
    pending_reqs.push_back(r);
    r = '{OP_DIV, 32'h80000000, 32'h1};
    pending_reqs.push_back(r);
    r = '{OP_MUL, 32'h180, 32'h1};
    pending_reqs.push_back(r);
    r = '{OP_TOINT, 32'hffffff01, 32'd0};
    pending_reqs.push_back(r);
    r = '{OP_CMP, 32'd5, 32'd5};
    pending_reqs.push_back(r);
    wait (pending_reqs.size() == 0 && !start);
    // pause until everything has drained
    hold_sender = 1'b1;
    wait (expected_res.size() == 0);
    repeat (LAT + 2) @(posedge clk);
    hold_sender = 1'b0;
    // random part
    for (int i = 0; i < 1700; i++) begin
      r.req_type = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                 : 4'($urandom_range(0, 10));
      r.operand_a = rand_operand();
      r.operand_b = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_operand();
      pending_reqs.push_back(r);
    end
    wait (pending_reqs.size() == 0 && !start);
    wait (expected_res.size() == 0);
    repeat (LAT + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule

/* sim.f */
hdl/fpa_pkg.sv
hdl/fpa_mul.sv
hdl/fpa_div.sv
hdl/q24_8_fixed_point_alu.sv
dv/tb.sv
